// ----- rtl/core/fcf_pkg.sv -----
package fcf_pkg;

  localparam int unsigned SAMP_W = 16;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned TC_W   = 9;
  localparam int unsigned OUT_W  = 40;
  localparam int unsigned PROD_W = 2 * SAMP_W;

  localparam logic [TC_W-1:0] TAP_COUNT_RESET = TC_W'(1);

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_PUSH  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]              func;
    logic [IDX_W-1:0]        coef_index;
    logic signed [SAMP_W-1:0] value;
  } fcf_req_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered;
  } fcf_res_t;

  typedef struct packed {
    logic [TC_W-1:0] tap_count;
  } fcf_cfg_t;

  // shared controls broadcast to every cell of the chain
  typedef struct packed {
    logic clear;
    logic shift;
    logic rotate;
  } fcf_cell_ctrl_t;

endpackage

// ----- rtl/core/fcf_stream_if.sv -----
interface fcf_stream_if #(
  parameter type data_t = logic
) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/fcf_cell.sv -----
module fcf_cell (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  fcf_pkg::fcf_cell_ctrl_t               ctrl_i,
  input  logic                                  load_i,
  input  logic signed [fcf_pkg::SAMP_W-1:0]     load_coef_i,
  input  logic signed [fcf_pkg::SAMP_W-1:0]     shift_samp_i,
  input  logic signed [fcf_pkg::SAMP_W-1:0]     rot_samp_i,
  input  logic signed [fcf_pkg::SAMP_W-1:0]     rot_coef_i,
  output logic signed [fcf_pkg::SAMP_W-1:0]     samp_o,
  output logic signed [fcf_pkg::SAMP_W-1:0]     coef_o
);

  logic signed [fcf_pkg::SAMP_W-1:0] samp_q;
  logic signed [fcf_pkg::SAMP_W-1:0] coef_q;

  // history entry: zero after reset and on clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samp_q <= '0;
    end else if (ctrl_i.clear) begin
      samp_q <= '0;
    end else if (ctrl_i.shift) begin
      samp_q <= shift_samp_i;
    end else if (ctrl_i.rotate) begin
      samp_q <= rot_samp_i;
    end
  end

  // coefficient: no reset, defined once loaded
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      coef_q <= load_coef_i;
    end else if (ctrl_i.rotate) begin
      coef_q <= rot_coef_i;
    end
  end

  assign samp_o = samp_q;
  assign coef_o = coef_q;

endmodule

// ----- rtl/core/fcf_mac.sv -----
module fcf_mac #(
  parameter int unsigned ACC_W = 40
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  clr_i,
  input  logic                                  en_i,
  input  logic signed [fcf_pkg::SAMP_W-1:0]     coef_i,
  input  logic signed [fcf_pkg::SAMP_W-1:0]     samp_i,
  output logic signed [fcf_pkg::OUT_W-1:0]      sum_o
);

  logic signed [fcf_pkg::PROD_W-1:0] prod_q;
  logic                              prod_en_q;
  logic signed [ACC_W-1:0]           acc_q;

  // product register; the accumulator adds it in the following cycle
  always_ff @(posedge clk_i) begin
    prod_q <= coef_i * samp_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_en_q <= 1'b0;
      acc_q     <= '0;
    end else begin
      prod_en_q <= en_i;
      if (clr_i) begin
        acc_q <= '0;
      end else if (prod_en_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  if (ACC_W > fcf_pkg::OUT_W) begin : g_sat
    localparam logic signed [ACC_W-1:0] SatMax =
      {{(ACC_W-fcf_pkg::OUT_W+1){1'b0}}, {(fcf_pkg::OUT_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SatMin =
      {{(ACC_W-fcf_pkg::OUT_W+1){1'b1}}, {(fcf_pkg::OUT_W-1){1'b0}}};
    always_comb begin
      if (acc_q > SatMax) begin
        sum_o = SatMax[fcf_pkg::OUT_W-1:0];
      end else if (acc_q < SatMin) begin
        sum_o = SatMin[fcf_pkg::OUT_W-1:0];
      end else begin
        sum_o = acc_q[fcf_pkg::OUT_W-1:0];
      end
    end
  end else begin : g_ext
    assign sum_o = fcf_pkg::OUT_W'(acc_q);
  end

endmodule

// ----- rtl/core/fir_convolution_filter.sv -----
// Streaming direct-form FIR filter (convolution with an impulse response).
//
// Channels: req_i carries requests {func, coef_index, value}; res_o returns
// one 40-bit Q30 sum per sample push; cfg_i writes tap_count (always ready).
//   func LOAD  stores value as coefficient coef_index (ignored if >= TAPS).
//   func PUSH  shifts value into the history and computes one sum.
//   func CLEAR zeroes the history; coefficients and tap_count stay.
// Loads and clears complete as they are taken. In a push, the history and
// coefficient rings rotate through the cell chain once past a single
// multiply-accumulate unit at cell 0; then ST_DRAIN empties the product
// register and ST_DONE moves the sum into the output register. Only taps
// below tap_count are accumulated (zero counts as one).
// req_i.ready is high only between pushes. The output register lets a new
// request in while a result waits; a finished sum is held back until the
// output register is free, so a stalled receiver stalls the block only then.
// Reset clears the history and sets tap_count to 1; coefficients hold
// nothing defined until loaded.
module fir_convolution_filter #(
  parameter int unsigned TAPS = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  fcf_stream_if.sink         req_i,
  fcf_stream_if.sink         cfg_i,
  fcf_stream_if.source       res_o
);

  localparam int unsigned STEP_W = $clog2(TAPS);
  localparam int unsigned CMP_W  = (fcf_pkg::TC_W > STEP_W) ? fcf_pkg::TC_W : STEP_W;
  localparam int unsigned ACC_W  = fcf_pkg::PROD_W + $clog2(TAPS);
  localparam logic [STEP_W-1:0] LastStep = STEP_W'(TAPS - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic [STEP_W-1:0]             step_q, step_d;
  logic [fcf_pkg::TC_W-1:0]      tap_count_q;
  logic                          res_valid_q;
  logic signed [fcf_pkg::OUT_W-1:0] res_data_q;

  fcf_pkg::fcf_req_t             req;
  logic                          req_take;
  logic                          res_load;
  logic                          acc_clr;
  logic                          mac_en;
  logic [fcf_pkg::TC_W-1:0]      eff_taps;
  logic signed [fcf_pkg::OUT_W-1:0] sum;
  fcf_pkg::fcf_cell_ctrl_t       cell_ctrl;

  logic signed [fcf_pkg::SAMP_W-1:0] samp_w [TAPS];
  logic signed [fcf_pkg::SAMP_W-1:0] coef_w [TAPS];

  assign req      = req_i.data;
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_take = req_i.valid && req_i.ready;

  // tap_count: host must write it only while no push is in flight (not enforced)
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= fcf_pkg::TAP_COUNT_RESET;
    end else if (cfg_i.valid) begin
      tap_count_q <= cfg_i.data.tap_count;
    end
  end

  // zero taps behaves as one; counts above TAPS never matter since
  // the step counter stays below TAPS
  assign eff_taps = (tap_count_q == '0) ? fcf_pkg::TC_W'(1) : tap_count_q;
  assign mac_en   = (state_q == ST_RUN) && (CMP_W'(step_q) < CMP_W'(eff_taps));

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    acc_clr  = 1'b0;
    res_load = 1'b0;
    cell_ctrl = '0;
    case (state_q)
      ST_IDLE: begin
        if (req_take) begin
          case (req.func)
            fcf_pkg::FUNC_PUSH: begin
              cell_ctrl.shift = 1'b1;
              acc_clr = 1'b1;
              step_d  = '0;
              state_d = ST_RUN;
            end
            fcf_pkg::FUNC_CLEAR: begin
              cell_ctrl.clear = 1'b1;
            end
            default: begin
              // loads are decoded per cell; func 3 does nothing
            end
          endcase
        end
      end
      ST_RUN: begin
        cell_ctrl.rotate = 1'b1;
        step_d = step_q + STEP_W'(1);
        if (step_q == LastStep) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!res_valid_q || res_o.ready) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // cell chain: shift moves toward higher index, rotate toward cell 0
  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    localparam int unsigned Next = (i + 1) % TAPS;
    logic                              load;
    logic signed [fcf_pkg::SAMP_W-1:0] shift_in;

    assign load = req_take && (req.func == fcf_pkg::FUNC_LOAD) &&
                  (32'(req.coef_index) == i);
    if (i == 0) begin : g_head
      assign shift_in = req.value;
    end else begin : g_body
      assign shift_in = samp_w[i-1];
    end

    fcf_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .load_i       (load),
      .load_coef_i  (req.value),
      .shift_samp_i (shift_in),
      .rot_samp_i   (samp_w[Next]),
      .rot_coef_i   (coef_w[Next]),
      .samp_o       (samp_w[i]),
      .coef_o       (coef_w[i])
    );
  end

  fcf_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (acc_clr),
    .en_i   (mac_en),
    .coef_i (coef_w[0]),
    .samp_i (samp_w[0]),
    .sum_o  (sum)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_data_q <= sum;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.data.filtered = res_data_q;

  a_push_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_take && req.func == fcf_pkg::FUNC_PUSH) |=> (state_q == ST_RUN && step_q == '0))
    else $error("push did not start a rotation pass");

  a_last_step_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && step_q == LastStep) |=> (state_q == ST_DRAIN))
    else $error("rotation pass did not end after TAPS steps");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && res_valid_q && !res_o.ready) |=> (state_q == ST_DONE))
    else $error("pending result overwritten");

  a_no_req_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> !req_take)
    else $error("request taken during a rotation pass");

endmodule

// ----- tb/fir_convolution_filter_tb.sv -----
`timescale 1ns / 1ps

// FIR filter testbench. Requests (loads, pushes, clears, unused codes) go in
// through req_if with random gaps, sums come back through res_if with random
// stalls, and each sum is checked against a local model of the filter.
module fir_convolution_filter_tb;

  localparam int unsigned TAPS = 256;
  // long enough for a whole push, with margin on top, before a cfg write
  localparam int unsigned SETTLE_CYCLES = TAPS + 8;
  // a push, a full sender gap, a full receiver stall and a settle fit many times
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned ITEMS_PER_PHASE = 14;
  localparam int unsigned PHASES = 9;
  // the fourth code has no meaning; the block must drop it silently
  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam logic signed [fcf_pkg::SAMP_W-1:0] SAMP_MAX =
    {1'b0, {(fcf_pkg::SAMP_W-1){1'b1}}};
  localparam logic signed [fcf_pkg::SAMP_W-1:0] SAMP_MIN =
    {1'b1, {(fcf_pkg::SAMP_W-1){1'b0}}};
  localparam logic signed [fcf_pkg::OUT_W-1:0] SUM_MAX =
    {1'b0, {(fcf_pkg::OUT_W-1){1'b1}}};
  localparam logic signed [fcf_pkg::OUT_W-1:0] SUM_MIN =
    {1'b1, {(fcf_pkg::OUT_W-1){1'b0}}};

  // Tracks history, coefficients and tap_count; queues one sum per push.
  class fir_scoreboard;
    logic signed [fcf_pkg::SAMP_W-1:0] history [TAPS];
    logic signed [fcf_pkg::SAMP_W-1:0] coef_mem [TAPS];
    logic [fcf_pkg::TC_W-1:0] tap_count;
    logic signed [fcf_pkg::OUT_W-1:0] sums_due [$];
    int unsigned errors;

    function new();
      foreach (history[k]) begin
        history[k] = '0;
        coef_mem[k] = '0;
      end
      tap_count = fcf_pkg::TAP_COUNT_RESET;
      errors = 0;
    endfunction

    // zero means one tap, anything past the store means all of it
    function int unsigned active_taps();
      if (tap_count == 0) return 1;
      if (tap_count > TAPS) return TAPS;
      return tap_count;
    endfunction

    function void note_request(fcf_pkg::fcf_req_t r);
      longint acc;
      int k;
      case (r.func)
        fcf_pkg::FUNC_LOAD: begin
          if (r.coef_index < TAPS) coef_mem[r.coef_index] = r.value;
        end
        fcf_pkg::FUNC_CLEAR: begin
          foreach (history[j]) history[j] = '0;
        end
        fcf_pkg::FUNC_PUSH: begin
          for (k = TAPS - 1; k > 0; k--) history[k] = history[k-1];
          history[0] = r.value;
          acc = 0;
          for (k = 0; k < active_taps(); k++) begin
            acc += longint'(coef_mem[k]) * longint'(history[k]);
          end
          if (acc > SUM_MAX) acc = SUM_MAX;
          if (acc < SUM_MIN) acc = SUM_MIN;
          sums_due.push_back(fcf_pkg::OUT_W'(acc));
        end
        default: ;
      endcase
    endfunction

    function void check_result(fcf_pkg::fcf_res_t r);
      logic signed [fcf_pkg::OUT_W-1:0] want;
      if (sums_due.size() == 0) begin
        $error("filtered: expected none, actual %0d", r.filtered);
        errors++;
        return;
      end
      want = sums_due.pop_front();
      if (r.filtered !== want) begin
        $error("filtered: expected %0d, actual %0d", want, r.filtered);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   no_idle;
  int unsigned quiet_cycles;
  logic [fcf_pkg::TC_W-1:0] tap_plan [PHASES];
  fir_scoreboard board = new();

  fcf_stream_if #(.data_t(fcf_pkg::fcf_req_t)) req_if ();
  fcf_stream_if #(.data_t(fcf_pkg::fcf_cfg_t)) cfg_if ();
  fcf_stream_if #(.data_t(fcf_pkg::fcf_res_t)) res_if ();

  fir_convolution_filter #(
    .TAPS(TAPS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .cfg_i (cfg_if),
    .res_o (res_if)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 12);
  endfunction

  // full-scale and zero values show up far more often than plain random
  function automatic logic signed [fcf_pkg::SAMP_W-1:0] draw_value();
    case ($urandom_range(0, 7))
      0: return SAMP_MIN;
      1: return SAMP_MAX;
      2: return '0;
      default: return fcf_pkg::SAMP_W'($urandom);
    endcase
  endfunction

  // One request: optional gap with valid low, then hold valid until taken.
  // Valid stays high into the next request when its gap is zero.
  task automatic send_request(logic [1:0] func, logic [fcf_pkg::IDX_W-1:0] idx,
                              logic signed [fcf_pkg::SAMP_W-1:0] value);
    fcf_pkg::fcf_req_t r;
    int unsigned gap;
    r.func = func;
    r.coef_index = idx;
    r.value = value;
    gap = draw_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid = 1'b1;
    req_if.data = r;
    do @(posedge clk_i); while (!req_if.ready);
    board.note_request(r);
  endtask

  // Sender holds off until every sum is back, then lets a trailing load or
  // clear finish, so the block is idle afterwards.
  task automatic drain();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (board.sums_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_tap_count(logic [fcf_pkg::TC_W-1:0] tc);
    drain();
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.data = fcf_pkg::fcf_cfg_t'(tc);
    do @(posedge clk_i); while (!cfg_if.ready);
    board.tap_count = tc;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Mostly pushes, with loads anywhere in the store, a few clears, runs of
  // zero samples as a host sends to flush the tail, and some unused codes.
  // Every coefficient is loaded before this runs, so any tap_count is safe.
  task automatic run_random_phase(int unsigned count);
    int unsigned done;
    int unsigned pick;
    int unsigned tail;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_request(fcf_pkg::FUNC_PUSH, fcf_pkg::IDX_W'($urandom), draw_value());
        done++;
      end else if (pick < 80) begin
        send_request(fcf_pkg::FUNC_LOAD, fcf_pkg::IDX_W'($urandom), draw_value());
        done++;
      end else if (pick < 86) begin
        send_request(fcf_pkg::FUNC_CLEAR, fcf_pkg::IDX_W'($urandom), draw_value());
        done++;
      end else if (pick < 94) begin
        tail = board.active_taps() - 1;
        if (tail > 12) tail = 12;
        repeat (tail) send_request(fcf_pkg::FUNC_PUSH, fcf_pkg::IDX_W'($urandom), '0);
        done += tail;
      end else begin
        // dropped by the block, so not counted
        send_request(FUNC_NONE, fcf_pkg::IDX_W'($urandom), draw_value());
      end
    end
  endtask

  // Receiver: per result either ready stays up, or it waits for valid and
  // then holds off a random number of cycles, so stalls hit a waiting sum.
  initial begin
    int unsigned stall;
    res_if.ready = 1'b0;
    forever begin
      stall = draw_gap();
      @(negedge clk_i);
      if (stall > 0) begin
        res_if.ready = 1'b0;
        do @(posedge clk_i); while (!res_if.valid);
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready = 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) board.check_result(res_if.data);
  end

  // Watchdog: any handshake restarts the count.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (cfg_if.valid && cfg_if.ready) ||
        (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int i;
    quiet_cycles = 0;
    no_idle = 1'b0;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    // full store, no taps, the saturating range, then assorted counts
    tap_plan = '{9'd256, 9'd0, 9'd511, 9'd257, 9'd2, 9'd17,
                 fcf_pkg::TC_W'($urandom_range(1, 256)), 9'd255, 9'd1};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, at the reset tap count of one: only coefficient 0 is read,
    // so it is loaded before the first push.
    send_request(fcf_pkg::FUNC_LOAD, '0, SAMP_MAX);
    send_request(fcf_pkg::FUNC_PUSH, '0, SAMP_MAX);
    send_request(fcf_pkg::FUNC_PUSH, '1, SAMP_MIN);
    send_request(fcf_pkg::FUNC_LOAD, '0, SAMP_MIN);
    send_request(fcf_pkg::FUNC_PUSH, 8'h5a, SAMP_MIN);   // largest positive product
    send_request(fcf_pkg::FUNC_PUSH, '0, SAMP_MAX);
    send_request(fcf_pkg::FUNC_PUSH, '0, '0);
    send_request(FUNC_NONE, '1, '1);                     // unused code: no sum, no change
    send_request(fcf_pkg::FUNC_PUSH, '0, 16'sd1);
    send_request(fcf_pkg::FUNC_CLEAR, '1, SAMP_MAX);     // history only, coefficient kept
    send_request(fcf_pkg::FUNC_PUSH, '0, SAMP_MIN);
    send_request(fcf_pkg::FUNC_LOAD, '1, SAMP_MAX);      // top index
    send_request(fcf_pkg::FUNC_LOAD, 8'd1, '1);
    send_request(fcf_pkg::FUNC_LOAD, '0, '1);
    send_request(fcf_pkg::FUNC_PUSH, '0, '1);
    send_request(fcf_pkg::FUNC_PUSH, 8'ha5, SAMP_MAX);

    // fill the whole coefficient store so later tap counts read loaded taps
    for (i = 0; i < TAPS; i++) begin
      send_request(fcf_pkg::FUNC_LOAD, fcf_pkg::IDX_W'(i), draw_value());
    end
    run_random_phase(ITEMS_PER_PHASE / 2);

    // tap_count changes only while idle; one phase in three runs with no gaps
    for (i = 0; i < PHASES; i++) begin
      no_idle = (i % 3 == 1);
      write_tap_count(tap_plan[i]);
      run_random_phase(ITEMS_PER_PHASE);
    end
    no_idle = 1'b0;

    drain();
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
